// ===== rtl/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// shared constants and types for the sync-byte packet deframer
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int BYTE_W          = 8;
    localparam int INDEX_W         = 6;
    localparam int PAYLOAD_LEN_DEF = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h81;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hA1;

    // bank token between parser, queue and emitter
    typedef struct packed {
        logic vld;
        logic bank;
    } tok_t;

endpackage

// ===== rtl/pdf_parse.sv =====
// ----------------------------------------------------------------------------
// pdf_parse
// front end: sync hunt, payload capture into a bank, fletcher-style check
// ----------------------------------------------------------------------------
module pdf_parse #(
    parameter int PAYLOAD_LEN = pdf_pkg::PAYLOAD_LEN_DEF,
    parameter int IDX_W       = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pdf_pkg::BYTE_W-1:0] s_tdata,
    output logic                      wr_en,
    output logic [IDX_W:0]            wr_addr,
    output logic [pdf_pkg::BYTE_W-1:0] wr_data,
    output pdf_pkg::tok_t             push,
    input  pdf_pkg::tok_t             done
);

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_SYNC2 = 3'd1;
    localparam logic [2:0] ST_DATA  = 3'd2;
    localparam logic [2:0] ST_CHK_A = 3'd3;
    localparam logic [2:0] ST_CHK_B = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic [pdf_pkg::BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [pdf_pkg::BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic                      wbank_reg, wbank_next;
    logic [1:0]                busy_reg, busy_next;
    logic                      acc;
    logic                      commit;
    logic [pdf_pkg::BYTE_W-1:0] a_upd;

    assign s_tready = !((state_reg == ST_DATA) && busy_reg[wbank_reg]);
    assign acc      = s_tvalid && s_tready;
    assign a_upd    = sum_a_reg + s_tdata;

    assign wr_en   = acc && (state_reg == ST_DATA);
    assign wr_addr = {wbank_reg, cnt_reg};
    assign wr_data = s_tdata;

    assign commit    = acc && (state_reg == ST_CHK_B) && (s_tdata == sum_b_reg);
    assign push.vld  = commit;
    assign push.bank = wbank_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (done.vld) begin
            busy_next[done.bank] = 1'b0;
        end
        if (acc) begin
            case (state_reg)
                ST_HUNT: begin
                    if (s_tdata == pdf_pkg::SYNC_FIRST) begin
                        state_next = ST_SYNC2;
                    end
                end
                ST_SYNC2: begin
                    state_next = (s_tdata == pdf_pkg::SYNC_SECOND) ? ST_DATA : ST_HUNT;
                    sum_a_next = '0;
                    sum_b_next = '0;
                    cnt_next   = '0;
                end
                ST_DATA: begin
                    sum_a_next = a_upd;
                    sum_b_next = sum_b_reg + a_upd;
                    cnt_next   = cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(PAYLOAD_LEN - 1)) begin
                        state_next = ST_CHK_A;
                    end
                end
                ST_CHK_A: begin
                    state_next = (s_tdata == sum_a_reg) ? ST_CHK_B : ST_HUNT;
                end
                ST_CHK_B: begin
                    state_next = ST_HUNT;
                    if (commit) begin
                        busy_next[wbank_reg] = 1'b1;
                        wbank_next           = !wbank_reg;
                    end
                end
                default: begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            cnt_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ===== rtl/pdf_fifo.sv =====
// ----------------------------------------------------------------------------
// pdf_fifo
// two-entry queue of finished packet banks between parser and emitter
// ----------------------------------------------------------------------------
module pdf_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  pdf_pkg::tok_t push,
    input  logic          pop,
    output pdf_pkg::tok_t head
);

    logic [1:0] bank_reg;
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign head.vld  = (cnt_reg != 2'd0);
    assign head.bank = bank_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push.vld) begin
            bank_reg[wptr_reg] <= push.bank;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (push.vld) begin
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push.vld} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/pdf_emit.sv =====
// ----------------------------------------------------------------------------
// pdf_emit
// back end: two-bank payload memory and byte-by-byte output sequencer
// ----------------------------------------------------------------------------
module pdf_emit #(
    parameter int PAYLOAD_LEN = pdf_pkg::PAYLOAD_LEN_DEF,
    parameter int IDX_W       = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [IDX_W:0]             wr_addr,
    input  logic [pdf_pkg::BYTE_W-1:0] wr_data,
    input  pdf_pkg::tok_t              head,
    output logic                       pop,
    output pdf_pkg::tok_t              done,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,  // payload_byte[7:0], byte_index[13:8]
    output logic                       m_tlast
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [pdf_pkg::BYTE_W-1:0] mem [0:(2 << IDX_W)-1];
    logic [pdf_pkg::BYTE_W-1:0] rdata_reg;

    logic [1:0]                 state_reg;
    logic                       bank_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [pdf_pkg::BYTE_W-1:0] byte_reg;
    logic [IDX_W-1:0]           oidx_reg;
    logic                       last_reg;
    logic                       valid_reg;
    pdf_pkg::tok_t              done_reg;
    logic                       is_last;

    assign is_last  = (idx_reg == IDX_W'(PAYLOAD_LEN - 1));
    assign pop      = (state_reg == B_IDLE) && head.vld;
    assign done     = done_reg;
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, pdf_pkg::INDEX_W'(oidx_reg), byte_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[{bank_reg, idx_reg}];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_LOAD) begin
            byte_reg <= rdata_reg;
            oidx_reg <= idx_reg;
            last_reg <= is_last;
        end
    end

    // bank release after its final item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= '0;
        end else begin
            done_reg.vld  <= (state_reg == B_OUT) && m_tready && is_last;
            done_reg.bank <= bank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            bank_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (head.vld) begin
                        bank_reg  <= head.bank;
                        idx_reg   <= '0;
                        state_reg <= B_RD;
                    end
                end
                B_RD: begin
                    state_reg <= B_LOAD;
                end
                B_LOAD: begin
                    valid_reg <= 1'b1;
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (m_tready) begin
                        valid_reg <= 1'b0;
                        if (is_last) begin
                            state_reg <= B_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= B_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/packet_deframer_with_checksum.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_with_checksum
// sync-byte packet deframer with fletcher-style check and payload replay
// ----------------------------------------------------------------------------
// s_ channel takes one received byte per item in s_tdata[7:0]; the front end
// hunts for 0x81 then 0xA1, stores PAYLOAD_LEN bytes into one of two memory
// banks and checks the two trailing sum bytes. a good packet queues its bank
// for the back end; a bad one is dropped with no output
// m_ channel gives one payload byte per item with its index, tlast on the
// final byte. input takes one byte per cycle except while the next packet's
// payload would land in a bank still being replayed; then s_tready drops
// the first output item appears after the bank token passes the queue and
// the back end's read and load states; the back end takes each byte through
// memory read, output load and handoff, plus receiver stall time, before it
// starts the next. a stalled receiver holds the output register and the front
// end keeps parsing into the free bank
// synchronous active-low reset returns to sync hunt with both banks free and
// empties the queue; memory contents are not cleared
// ----------------------------------------------------------------------------
module packet_deframer_with_checksum #(
    parameter int PAYLOAD_LEN = pdf_pkg::PAYLOAD_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // payload_byte[7:0], byte_index[13:8]
    output logic        m_tlast
);

    localparam int IDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

    logic                       wr_en;
    logic [IDX_W:0]             wr_addr;
    logic [pdf_pkg::BYTE_W-1:0] wr_data;
    pdf_pkg::tok_t              push;
    pdf_pkg::tok_t              head;
    pdf_pkg::tok_t              done;
    logic                       pop;

    pdf_parse #(
        .PAYLOAD_LEN (PAYLOAD_LEN),
        .IDX_W       (IDX_W)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (push),
        .done     (done)
    );

    pdf_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head)
    );

    pdf_emit #(
        .PAYLOAD_LEN (PAYLOAD_LEN),
        .IDX_W       (IDX_W)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .head     (head),
        .pop      (pop),
        .done     (done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/packet_deframer_with_checksum_test.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_with_checksum_test
// self-checking bench for the sync-byte packet deframer
// ----------------------------------------------------------------------------
// feeds byte streams built from framed packets (good, bad second sync, bad
// first or second check byte) mixed with noise, with payloads that are random,
// all zero, all ones or full of sync bytes. a scoreboard class tracks the
// framing and the running sums, queues the expected payload replay and checks
// every output item field by field. the sender idles in bursts and the
// receiver stalls on patterns of its own
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_deframer_with_checksum_test;

    localparam int PLEN        = pdf_pkg::PAYLOAD_LEN_DEF;
    localparam int ITEM_TARGET = 265;

    typedef enum logic [2:0] {HUNT, SYNC2, STORE, CHECK_A, CHECK_B} parse_t;
    typedef enum {PK_GOOD, PK_BAD_SYNC, PK_BAD_A, PK_BAD_B} pkt_t;
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_t;
    typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

    class deframer_scoreboard_t;
        parse_t          phase;
        logic [6:0]      stored;
        logic [7:0]      sum_a;
        logic [7:0]      sum_b;
        logic [7:0]      payload [PLEN];
        logic [7:0]      exp_byte [$];
        logic [5:0]      exp_index [$];
        logic            exp_last [$];
        int              errors;
        int              checked;
        int              good_packets;

        function new();
            phase = HUNT;
            stored = '0;
            sum_a = '0;
            sum_b = '0;
            errors = 0;
            checked = 0;
            good_packets = 0;
        endfunction

        function int pending();
            return exp_byte.size();
        endfunction

        function void note_input(input logic [7:0] b);
            case (phase)
                HUNT: begin
                    if (b == pdf_pkg::SYNC_FIRST) begin
                        phase = SYNC2;
                        stored = '0;
                    end
                end
                SYNC2: begin
                    phase = (b == pdf_pkg::SYNC_SECOND) ? STORE : HUNT;
                    sum_a = '0;
                    sum_b = '0;
                    stored = '0;
                end
                STORE: begin
                    if (stored < PLEN) payload[stored] = b;
                    stored = stored + 7'd1;
                    sum_a = sum_a + b;
                    sum_b = sum_b + sum_a;
                    if (stored >= PLEN) phase = CHECK_A;
                end
                CHECK_A: begin
                    phase = (b == sum_a) ? CHECK_B : HUNT;
                end
                CHECK_B: begin
                    phase = HUNT;
                    if (b == sum_b) begin
                        for (int k = 0; k < PLEN; k++) begin
                            exp_byte.push_back(payload[k]);
                            exp_index.push_back(6'(k));
                            exp_last.push_back(k == PLEN - 1);
                        end
                        good_packets++;
                    end
                end
                default: phase = HUNT;
            endcase
        endfunction

        function void check_result(input logic [15:0] data, input logic last);
            logic [7:0] want_byte;
            logic [5:0] want_index;
            logic       want_last;
            if (exp_byte.size() == 0) begin
                $display("%0t: unexpected output item, tdata %h tlast %b", $time, data, last);
                errors++;
                return;
            end
            want_byte = exp_byte.pop_front();
            want_index = exp_index.pop_front();
            want_last = exp_last.pop_front();
            checked++;
            if (data[7:0] !== want_byte) begin
                $display("%0t: payload_byte mismatch, expected %h, actual %h",
                         $time, want_byte, data[7:0]);
                errors++;
            end
            if (data[13:8] !== want_index) begin
                $display("%0t: byte_index mismatch, expected %0d, actual %0d",
                         $time, want_index, data[13:8]);
                errors++;
            end
            if (last !== want_last) begin
                $display("%0t: last_byte mismatch, expected %b, actual %b",
                         $time, want_last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    deframer_scoreboard_t sb;
    int          burst_left = 0;
    int          items_sent = 0;
    rx_mode_t    rx_mode    = RX_OPEN;
    int          rx_left    = 0;
    logic [2:0]  rx_tick    = '0;

    packet_deframer_with_checksum #(
        .PAYLOAD_LEN(PLEN)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver backpressure, mode changes every so often
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom);
            default:   m_tready <= (rx_tick == 3'd0);
        endcase
        rx_tick <= rx_tick + 3'd1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 60);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_packet(input pkt_t kind, input fill_t fill);
        logic [7:0] frame [$];
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] v;
        a = '0;
        c = '0;
        frame.push_back(pdf_pkg::SYNC_FIRST);
        if (kind == PK_BAD_SYNC) begin
            v = $urandom_range(0, 1) ? pdf_pkg::SYNC_FIRST : 8'($urandom);
            if (v == pdf_pkg::SYNC_SECOND) v = 8'h00;
            frame.push_back(v);
        end else begin
            frame.push_back(pdf_pkg::SYNC_SECOND);
            for (int i = 0; i < PLEN; i++) begin
                case (fill)
                    FILL_ZERO: v = 8'h00;
                    FILL_ONES: v = 8'hFF;
                    FILL_SYNC: v = $urandom_range(0, 2) == 0 ? 8'($urandom) :
                                   ($urandom_range(0, 1) ? pdf_pkg::SYNC_FIRST :
                                                           pdf_pkg::SYNC_SECOND);
                    default:   v = 8'($urandom);
                endcase
                a = a + v;
                c = c + a;
                frame.push_back(v);
            end
            frame.push_back(kind == PK_BAD_A ? a ^ 8'($urandom_range(1, 255)) : a);
            if (kind == PK_GOOD) frame.push_back(c);
            if (kind == PK_BAD_B) frame.push_back(c ^ 8'($urandom_range(1, 255)));
        end
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [7:0] lead [$];
        int         r;
        fill_t      f;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hunting noise, bad second sync where the 0x81 does not restart,
        // then two plain bad second syncs
        lead = '{8'h00, 8'hFF, pdf_pkg::SYNC_SECOND, pdf_pkg::SYNC_FIRST,
                 pdf_pkg::SYNC_FIRST, pdf_pkg::SYNC_SECOND, 8'h55, pdf_pkg::SYNC_FIRST,
                 8'h00, pdf_pkg::SYNC_SECOND, 8'hAA, pdf_pkg::SYNC_FIRST, 8'hFF};
        foreach (lead[i]) send_byte(lead[i]);

        send_packet(PK_GOOD, FILL_SYNC);
        send_packet(PK_GOOD, FILL_ZERO);
        // a failed first check is followed right away by a new sync byte
        send_packet(PK_BAD_A, FILL_RANDOM);
        send_packet(PK_GOOD, FILL_ONES);
        send_packet(PK_BAD_B, FILL_SYNC);

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            f = $urandom_range(0, 5) < 3 ? FILL_RANDOM : fill_t'($urandom_range(0, 3));
            if (r < 60) send_packet(PK_GOOD, f);
            else if (r < 70) send_packet(PK_BAD_SYNC, f);
            else if (r < 80) send_packet(PK_BAD_A, f);
            else if (r < 90) send_packet(PK_BAD_B, f);
            else repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (3 * PLEN + 16) @(posedge aclk);

        $display("sent %0d input items, %0d good packets replayed, %0d output items checked",
                 items_sent, sb.good_packets, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
